// ----- sv/rsi_wilder_stream_core_defines.svh -----
// Assertion macros for the RSI stream core.
// Expect clk_i and rst_ni in the scope of the module that uses them.
`ifndef RSI_WILDER_STREAM_CORE_DEFINES_SVH
`define RSI_WILDER_STREAM_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RSI_ASSERT_NEVER(lbl, cond, msg) \
  `RSI_ASSERT(lbl, !(cond), msg)
`else
`define RSI_ASSERT(lbl, prop, msg)
`define RSI_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- sv/rsi_pkg.sv -----
// Shared widths, codes and control structs of the RSI stream core.
// No dependencies.
package rsi_pkg;

  localparam int PRICE_W    = 32;
  localparam int AVG_FRAC   = 16;
  localparam int AVG_W      = PRICE_W + AVG_FRAC;
  localparam int PER_W      = 8;
  localparam int SUM_W      = PRICE_W + PER_W;
  localparam int ACC_W      = AVG_W + PER_W;
  localparam int LANE_CNT_W = $clog2(AVG_W);
  localparam int LEVEL_W    = 7;
  localparam int RSI_W      = 15;
  localparam int ZONE_W     = 2;
  localparam int RNUM_W     = AVG_W + RSI_W;
  localparam int RCNT_W     = $clog2(RSI_W);

  localparam int RSI_FULL   = 25600;
  // 25600 = 2^14 + 2^13 + 2^10
  localparam int RSI_SH0    = 14;
  localparam int RSI_SH1    = 13;
  localparam int RSI_SH2    = 10;

  typedef enum logic [ZONE_W-1:0] {
    ZONE_NONE  = 2'd0,
    ZONE_OVER  = 2'd1,
    ZONE_UNDER = 2'd2
  } zone_e;

  typedef struct packed {
    logic             start;
    logic [PER_W-1:0] mult;
    logic [PER_W-1:0] divisor;
  } lane_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

endpackage

// ----- sv/rsi_if.sv -----
// Valid/ready stream interfaces for price beats and RSI result beats.
// Depends on rsi_pkg.
interface rsi_in_if import rsi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] price;
  logic               restart;

  modport source (output valid, output price, output restart, input ready);
  modport sink   (input valid, input price, input restart, output ready);
endinterface

interface rsi_out_if import rsi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RSI_W-1:0]  rsi_value;
  logic [ZONE_W-1:0] zone;

  modport source (output valid, output rsi_value, output zone, input ready);
  modport sink   (input valid, input rsi_value, input zone, output ready);
endinterface

// ----- sv/rsi_wilder_stream_core.sv -----
// Streaming Wilder RSI core: top level with APB registers and ratio divider.
// Depends on rsi_pkg, rsi_if, rsi_lane and rsi_wilder_stream_core_defines.svh.
//
// Usage:
//   in_ch carries price beats (price, restart); out_ch carries result beats
//   (rsi_value in Q7.8, zone). A beat moves when valid and ready are high.
//   The first sample of a series and all seeding samples but the last give no result.
//   Registers at 0x0 smoothing_period, 0x4 upper_level, 0x8 lower_level;
//   write them only while the block is idle. Writing the period restarts
//   the series.
// Flow:
//   A sample without a result leaves the core idle, ready for the next one.
//   A sample with a result passes 8 shift-add and 48 divide steps in the
//   two smoothing lanes (run side by side), then S_SCALE and S_MUL1 to S_MUL3
//   to form 25600*gain plus half the sum, 15 steps of the gain/(gain+loss)
//   divider and S_DONE. The next sample is taken once the result is in the
//   output register, so no new sample is taken while a result is in work.
// Reset clears the series history and loads 14/70/30 into the registers.
// A stalled receiver holds the result in the output register; the core still
// takes the next sample and waits only when it has another result to place.
`include "rsi_wilder_stream_core_defines.svh"

module rsi_wilder_stream_core import rsi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsi_in_if.sink      in_ch,
  rsi_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_UPPER  = 2'd1;
  localparam logic [1:0] REG_LOWER  = 2'd2;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LANE  = 8'b0000_0010,
    S_SCALE = 8'b0000_0100,
    S_MUL1  = 8'b0000_1000,
    S_MUL2  = 8'b0001_0000,
    S_MUL3  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  // registers
  logic [PER_W-1:0]   period_q;
  logic [LEVEL_W-1:0] upper_q, lower_q;
  logic               cfg_wr;

  // series state
  logic [PRICE_W-1:0] prev_q;
  logic [PER_W:0]     seen_q;
  logic [AVG_W-1:0]   gain_q, loss_q;

  state_e             state_q, state_d;
  logic [RCNT_W-1:0]  rcnt_q, rcnt_d;
  logic               out_vld_q, out_vld_d;
  logic [RSI_W-1:0]   out_rsi_q;
  zone_e              out_zone_q;

  logic [AVG_W-2:0]   rg_q, rg_d;
  logic [AVG_W-1:0]   rs_q, rs_d;
  logic [RNUM_W-1:0]  racc_q, racc_d;

  logic [PER_W-1:0]   p_eff;
  logic               in_fire;
  logic [PER_W:0]     seen_eff;
  logic               first;
  logic               seeding;
  logic               up;
  logic [PRICE_W-1:0] gdiff, ldiff;
  logic [AVG_W-1:0]   gsum, lsum;
  logic [ACC_W-1:0]   gadd, ladd;
  lane_req_t          lane_req;
  lane_stat_t         gain_st, loss_st;
  logic [AVG_W-1:0]   gain_quot, loss_quot;
  logic [AVG_W-1:0]   gs, ls;
  logic [AVG_W:0]     trial, trial_sub;
  logic               ge;
  logic               load_out;
  logic [RSI_W-1:0]   rsi;
  zone_e              zone;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_PERIOD: prdata = 32'(period_q);
      REG_UPPER:  prdata = 32'(upper_q);
      REG_LOWER:  prdata = 32'(lower_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PER_W'(14);
      upper_q  <= LEVEL_W'(70);
      lower_q  <= LEVEL_W'(30);
    end else if (cfg_wr) begin
      if (paddr[3:2] == REG_PERIOD) period_q <= pwdata[PER_W-1:0];
      if (paddr[3:2] == REG_UPPER)  upper_q  <= pwdata[LEVEL_W-1:0];
      if (paddr[3:2] == REG_LOWER)  lower_q  <= pwdata[LEVEL_W-1:0];
    end
  end

  // input beat
  assign p_eff    = (period_q == '0) ? PER_W'(1) : period_q;
  assign in_ch.ready = state_q == S_IDLE;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign seen_eff = in_ch.restart ? '0 : seen_q;
  assign first    = seen_eff == '0;
  assign seeding  = !first && (seen_eff <= {1'b0, p_eff});

  assign up    = in_ch.price > prev_q;
  assign gdiff = up ? in_ch.price - prev_q : '0;
  assign ldiff = up ? '0 : prev_q - in_ch.price;
  assign gsum  = gain_q + AVG_W'(gdiff);
  assign lsum  = loss_q + AVG_W'(ldiff);

  always_comb begin
    if (seeding) begin
      gadd = {gsum[SUM_W-1:0], AVG_FRAC'(0)};
      ladd = {lsum[SUM_W-1:0], AVG_FRAC'(0)};
    end else begin
      gadd = ACC_W'({gdiff, AVG_FRAC'(0)});
      ladd = ACC_W'({ldiff, AVG_FRAC'(0)});
    end
  end

  assign lane_req.start   = in_fire && !first && (!seeding || seen_q == {1'b0, p_eff});
  assign lane_req.mult    = seeding ? '0 : p_eff - PER_W'(1);
  assign lane_req.divisor = p_eff;

  rsi_lane u_gain_lane (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (lane_req),
    .avg_i    (gain_q),
    .addend_i (gadd),
    .stat_o   (gain_st),
    .quot_o   (gain_quot)
  );

  rsi_lane u_loss_lane (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (lane_req),
    .avg_i    (loss_q),
    .addend_i (ladd),
    .stat_o   (loss_st),
    .quot_o   (loss_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      seen_q <= '0;
      gain_q <= '0;
      loss_q <= '0;
    end else if (in_fire) begin
      prev_q <= in_ch.price;
      if (first) begin
        seen_q <= (PER_W+1)'(1);
        gain_q <= '0;
        loss_q <= '0;
      end else if (seeding) begin
        seen_q <= seen_q + (PER_W+1)'(1);
        gain_q <= gsum;
        loss_q <= lsum;
      end
    end else if (state_q == S_LANE && gain_st.done) begin
      gain_q <= gain_quot;
      loss_q <= loss_quot;
    end else if (cfg_wr && paddr[3:2] == REG_PERIOD) begin
      seen_q <= '0;
    end
  end

  // gain / (gain + loss) ratio
  assign gs = (gain_q[AVG_W-1] || loss_q[AVG_W-1]) ? gain_q >> 1 : gain_q;
  assign ls = (gain_q[AVG_W-1] || loss_q[AVG_W-1]) ? loss_q >> 1 : loss_q;

  assign trial     = racc_q[RNUM_W-1 -: AVG_W+1];
  assign trial_sub = trial - {1'b0, rs_q};
  assign ge        = trial >= {1'b0, rs_q};

  assign rsi = (rs_q == '0) ? '0 : racc_q[RSI_W-1:0];

  always_comb begin
    if (rsi >= {upper_q, 8'b0})      zone = ZONE_OVER;
    else if (rsi <= {lower_q, 8'b0}) zone = ZONE_UNDER;
    else                             zone = ZONE_NONE;
  end

  assign load_out = state_q == S_DONE && (!out_vld_q || out_ch.ready);

  always_comb begin
    state_d   = state_q;
    rcnt_d    = rcnt_q;
    rg_d      = rg_q;
    rs_d      = rs_q;
    racc_d    = racc_q;
    out_vld_d = out_vld_q && !out_ch.ready;
    unique case (state_q)
      S_IDLE:  if (lane_req.start) state_d = S_LANE;
      S_LANE:  if (gain_st.done) state_d = S_SCALE;
      S_SCALE: begin
        rg_d    = gs[AVG_W-2:0];
        rs_d    = AVG_W'(gs[AVG_W-2:0]) + AVG_W'(ls[AVG_W-2:0]);
        state_d = S_MUL1;
      end
      S_MUL1: begin
        racc_d  = (RNUM_W'(rg_q) << RSI_SH0) + (RNUM_W'(rg_q) << RSI_SH1);
        state_d = S_MUL2;
      end
      S_MUL2: begin
        racc_d  = racc_q + (RNUM_W'(rg_q) << RSI_SH2);
        state_d = S_MUL3;
      end
      S_MUL3: begin
        // + sum/2 rounds half up
        racc_d  = racc_q + RNUM_W'(rs_q >> 1);
        rcnt_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        racc_d = {(ge ? trial_sub[AVG_W-1:0] : trial[AVG_W-1:0]), racc_q[RSI_W-2:0], ge};
        rcnt_d = rcnt_q + RCNT_W'(1);
        if (rcnt_q == RCNT_W'(RSI_W - 1)) state_d = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rcnt_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rcnt_q    <= rcnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rg_q   <= rg_d;
    rs_q   <= rs_d;
    racc_q <= racc_d;
    if (load_out) begin
      out_rsi_q  <= rsi;
      out_zone_q <= zone;
    end
  end

  assign out_ch.valid     = out_vld_q;
  assign out_ch.rsi_value = out_rsi_q;
  assign out_ch.zone      = out_zone_q;

  `RSI_ASSERT(a_lanes_lockstep, gain_st.done == loss_st.done, "smoothing lanes out of step")
  `RSI_ASSERT_NEVER(a_accept_busy_lane, in_ch.ready && gain_st.busy, "input taken while lane busy")
  `RSI_ASSERT(a_load_from_done, out_vld_q && !$past(out_vld_q) |-> $past(state_q == S_DONE), "result beat without finished ratio")
  `RSI_ASSERT(a_rsi_range, out_vld_q |-> out_rsi_q <= RSI_W'(RSI_FULL), "rsi_value beyond full scale")

endmodule

// ----- sv/rsi_lane.sv -----
// One smoothing lane: acc = mult * avg + addend by serial shift-add, then
// acc / divisor by a restoring divider, one quotient bit per cycle. Uses rsi_pkg.
module rsi_lane import rsi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lane_req_t        req_i,
  input  logic [AVG_W-1:0] avg_i,
  input  logic [ACC_W-1:0] addend_i,
  output lane_stat_t       stat_o,
  output logic [AVG_W-1:0] quot_o
);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_MUL  = 3'b010,
    L_DIV  = 3'b100
  } lane_state_e;

  lane_state_e           state_q, state_d;
  logic [LANE_CNT_W-1:0] cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [PER_W-1:0]      m_q, m_d;
  logic [PER_W-1:0]      div_q, div_d;
  logic [ACC_W-1:0]      a_q, a_d;
  logic [ACC_W-1:0]      acc_q, acc_d;

  logic [PER_W:0]        trial;
  logic [PER_W:0]        trial_sub;
  logic                  ge;
  logic [ACC_W-1:0]      mac;

  // acc holds {remainder, dividend/quotient} during division
  assign trial     = acc_q[ACC_W-1 -: PER_W+1];
  assign trial_sub = trial - {1'b0, div_q};
  assign ge        = trial >= {1'b0, div_q};
  assign mac       = m_q[0] ? acc_q + a_q : acc_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    m_d     = m_q;
    div_d   = div_q;
    a_d     = a_q;
    acc_d   = acc_q;
    unique case (state_q)
      L_IDLE: begin
        if (req_i.start) begin
          m_d     = req_i.mult;
          div_d   = req_i.divisor;
          a_d     = ACC_W'(avg_i);
          acc_d   = addend_i;
          cnt_d   = '0;
          state_d = L_MUL;
        end
      end
      L_MUL: begin
        acc_d = mac;
        a_d   = a_q << 1;
        m_d   = m_q >> 1;
        cnt_d = cnt_q + LANE_CNT_W'(1);
        if (cnt_q == LANE_CNT_W'(PER_W - 1)) begin
          cnt_d   = '0;
          state_d = L_DIV;
        end
      end
      L_DIV: begin
        acc_d = {(ge ? trial_sub[PER_W-1:0] : trial[PER_W-1:0]), acc_q[AVG_W-2:0], ge};
        cnt_d = cnt_q + LANE_CNT_W'(1);
        if (cnt_q == LANE_CNT_W'(AVG_W - 1)) begin
          cnt_d   = '0;
          done_d  = 1'b1;
          state_d = L_IDLE;
        end
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    div_q <= div_d;
    a_q   <= a_d;
    acc_q <= acc_d;
  end

  assign stat_o.busy = state_q != L_IDLE;
  assign stat_o.done = done_q;
  assign quot_o      = acc_q[AVG_W-1:0];

endmodule

// ----- test/rsi_tb_pkg.sv -----
`timescale 1ns / 1ps
// Register indexes of the RSI stream core, shared by the testbench files.
// No dependencies.
package rsi_tb_pkg;

  typedef enum logic [1:0] {
    REG_PERIOD   = 2'd0,
    REG_UPPER    = 2'd1,
    REG_LOWER    = 2'd2,
    REG_UNMAPPED = 2'd3
  } reg_idx_e;

endpackage

// ----- test/rsi_stream_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the RSI stream core: tracks register writes and price beats,
// predicts each RSI/zone result and compares the result beats in order.
// Depends on rsi_pkg and rsi_tb_pkg.
module rsi_stream_checker import rsi_pkg::*; import rsi_tb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [PRICE_W-1:0] in_price_i,
  input  logic               in_restart_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [RSI_W-1:0]   out_rsi_i,
  input  logic [ZONE_W-1:0]  out_zone_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [3:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [RSI_W-1:0] rsi_value;
    zone_e            zone;
  } rsi_result_t;

  rsi_result_t  pending_rsi_q[$];
  int           mismatch_count;

  logic [7:0]          period_q;
  logic [LEVEL_W-1:0]  upper_q;
  logic [LEVEL_W-1:0]  lower_q;
  logic [PRICE_W-1:0]  last_price_q;
  logic [8:0]          seen_q;
  logic [63:0]         gain_avg_q;
  logic [63:0]         loss_avg_q;

  assign fail_count_o = mismatch_count;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic logic [RSI_W-1:0] rsi_ratio(input logic [63:0] gain_in,
                                                 input logic [63:0] loss_in);
    logic [63:0] g;
    logic [63:0] l;
    logic [63:0] s;
    g = gain_in;
    l = loss_in;
    while (g >= (64'd1 << 47) || l >= (64'd1 << 47)) begin
      g = g >> 1;
      l = l >> 1;
    end
    s = g + l;
    if (s == 64'd0) return '0;
    return RSI_W'((64'(RSI_FULL) * g + s / 64'd2) / s);
  endfunction

  task automatic queue_result();
    rsi_result_t want;
    want.rsi_value = rsi_ratio(gain_avg_q, loss_avg_q);
    if (32'(want.rsi_value) >= 32'(upper_q) * 32'd256) begin
      want.zone = ZONE_OVER;
    end else if (32'(want.rsi_value) <= 32'(lower_q) * 32'd256) begin
      want.zone = ZONE_UNDER;
    end else begin
      want.zone = ZONE_NONE;
    end
    pending_rsi_q.insert(pending_rsi_q.size(), want);
  endtask

  task automatic advance_series(input logic [PRICE_W-1:0] price, input logic restart);
    logic [63:0] p;
    logic [63:0] up;
    logic [63:0] dn;
    p  = (period_q == 8'd0) ? 64'd1 : 64'(period_q);
    up = '0;
    dn = '0;
    if (restart) begin
      last_price_q = '0;
      seen_q       = '0;
      gain_avg_q   = '0;
      loss_avg_q   = '0;
    end
    if (seen_q == 9'd0) begin
      gain_avg_q   = '0;
      loss_avg_q   = '0;
      last_price_q = price;
      seen_q       = 9'd1;
      return;
    end
    if (price > last_price_q) up = 64'(price - last_price_q);
    else dn = 64'(last_price_q - price);
    last_price_q = price;
    if (64'(seen_q) <= p) begin
      gain_avg_q = gain_avg_q + up;
      loss_avg_q = loss_avg_q + dn;
      seen_q     = seen_q + 9'd1;
      if (64'(seen_q) < p + 64'd1) return;
      gain_avg_q = (gain_avg_q << AVG_FRAC) / p;
      loss_avg_q = (loss_avg_q << AVG_FRAC) / p;
    end else begin
      seen_q     = 9'(p + 64'd1);
      gain_avg_q = ((p - 64'd1) * gain_avg_q + (up << AVG_FRAC)) / p;
      loss_avg_q = ((p - 64'd1) * loss_avg_q + (dn << AVG_FRAC)) / p;
    end
    queue_result();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsi_result_t want;
    if (!rst_ni) begin
      period_q     = 8'd14;
      upper_q      = 7'd70;
      lower_q      = 7'd30;
      last_price_q = '0;
      seen_q       = '0;
      gain_avg_q   = '0;
      loss_avg_q   = '0;
      pending_rsi_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_rsi_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat rsi_value=%0d zone=%0d",
                                    out_rsi_i, out_zone_i));
        end else begin
          want = pending_rsi_q.pop_front();
          if (out_rsi_i !== want.rsi_value)
            report_mismatch($sformatf("rsi_value got %0d want %0d",
                                      out_rsi_i, want.rsi_value));
          if (out_zone_i !== want.zone)
            report_mismatch($sformatf("zone got %0d want %0d (rsi_value %0d)",
                                      out_zone_i, want.zone, want.rsi_value));
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[3:2]))
          REG_PERIOD: begin
            period_q = pwdata_i[7:0];
            seen_q   = '0;
          end
          REG_UPPER: upper_q = pwdata_i[LEVEL_W-1:0];
          REG_LOWER: lower_q = pwdata_i[LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) advance_series(in_price_i, in_restart_i);
      pending_o <= pending_rsi_q.size();
    end
  end

endmodule

// ----- test/tb_rsi_wilder_stream_core.sv -----
`timescale 1ns / 1ps
// Top of the RSI stream core testbench: clock, reset, price beats, register
// writes and result back-pressure. Checking is done by rsi_stream_checker.
// Depends on rsi_pkg, rsi_tb_pkg, rsi_if, rsi_stream_checker and the core.
module tb_rsi_wilder_stream_core;
  import rsi_pkg::*;
  import rsi_tb_pkg::*;

  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          idle_cycles;
  bit          no_gaps;
  logic [PRICE_W-1:0] walk_price;

  rsi_in_if  in_ch ();
  rsi_out_if out_ch ();

  rsi_wilder_stream_core dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rsi_stream_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_price_i   (in_ch.price),
    .in_restart_i (in_ch.restart),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_rsi_i    (out_ch.rsi_value),
    .out_zone_i   (out_ch.zone),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (no_gaps || sel < 55) return 0;
    if (sel < 90) return int'($urandom_range(1, 3));
    if (sel < 98) return int'($urandom_range(4, 20));
    return int'($urandom_range(30, 150));
  endfunction

  function automatic logic [PRICE_W-1:0] next_price(input logic [PRICE_W-1:0] last);
    int unsigned sel;
    logic [PRICE_W-1:0] step;
    sel  = $urandom_range(0, 99);
    step = PRICE_W'($urandom_range(0, 1000));
    if (sel < 8) return PRICE_W'($urandom());
    if (sel < 11) return '1;
    if (sel < 14) return '0;
    if (sel < 22) return last;
    if (sel < 61) return last + step;
    return last - step;
  endfunction

  task automatic push_sample(input logic [PRICE_W-1:0] price, input logic restart);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.price   <= price;
    in_ch.restart <= restart;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // upper bits of the write data are junk the block must drop
  task automatic run_phase(input bit set_period, input logic [7:0] period,
                           input logic [6:0] upper, input logic [6:0] lower,
                           input int n_items, input int restart_pct, input bit calm);
    wait_idle();
    if (set_period) reg_write(REG_PERIOD, ($urandom() & 32'hFFFF_FF00) | 32'(period));
    reg_write(REG_UPPER, ($urandom() & 32'hFFFF_FF80) | 32'(upper));
    reg_write(REG_LOWER, ($urandom() & 32'hFFFF_FF80) | 32'(lower));
    if ($urandom_range(0, 1) == 0) reg_write(REG_UNMAPPED, $urandom());
    no_gaps = calm;
    repeat (n_items) begin
      if ($urandom_range(0, 199) == 0) wait_idle();
      walk_price = next_price(walk_price);
      push_sample(walk_price, int'($urandom_range(0, 99)) < restart_pct);
    end
    no_gaps = 1'b0;
  endtask

  initial begin : result_sink
    int hold;
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      hold = int'($urandom_range(1, 40));
      out_ch.ready <= 1'b1;
      repeat (hold) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.price   = '0;
    in_ch.restart = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    no_gaps       = 1'b0;
    idle_cycles   = 0;
    walk_price    = PRICE_W'(32'd50000);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 14-beat seed of pure gains, then one fall
    for (int k = 0; k < 15; k++) push_sample(PRICE_W'(100 + 10 * k), 1'b0);
    push_sample(PRICE_W'(40), 1'b0);
    wait_idle();
    reg_write(REG_PERIOD, 32'd1);
    // full-scale rise and fall, flat price, restart mid-series
    push_sample('0, 1'b1);
    push_sample('1, 1'b0);
    push_sample('0, 1'b0);
    push_sample('0, 1'b0);
    push_sample(PRICE_W'(5), 1'b1);
    push_sample(PRICE_W'(5), 1'b0);
    push_sample(PRICE_W'(7), 1'b0);

    run_phase(1'b1, 8'd3,   7'd70,  7'd30,  80,  3, 1'b0);
    run_phase(1'b1, 8'd1,   7'd100, 7'd0,   60,  3, 1'b1);
    run_phase(1'b1, 8'd0,   7'd0,   7'd100, 60,  3, 1'b0);
    run_phase(1'b1, 8'd5,   7'd127, 7'd100, 60,  3, 1'b0);
    run_phase(1'b0, 8'd5,   7'd90,  7'd10,  40,  2, 1'b0);
    run_phase(1'b1, 8'd255, 7'd50,  7'd50,  270, 0, 1'b0);
    run_phase(1'b1, 8'd2, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
              80, 4, 1'b0);
    for (int k = 0; k < 6; k++) begin
      run_phase(1'b1, 8'($urandom_range(1, 20)), 7'($urandom_range(40, 127)),
                7'($urandom_range(0, 60)), 50, 3, k == 2);
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
